// ===== design/ppsub_pkg.sv =====
//------------------------------------------------------------------------------
// ppsub_pkg
// Shared constants, codes and controller/datapath bundles for the residue
// profile pseudocount and substitution block.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ppsub_pkg;

    localparam int NUM_RESIDUES_DEF = 20;

    localparam int ACT_W   = 3;
    localparam int IDX_W   = 5;
    localparam int VAL_W   = 16;
    localparam int ST_W    = 2;
    localparam int PROF_W  = 40;
    localparam int TOTAL_W = 21;
    localparam int QUO_W   = 17;
    localparam int STEP_W  = 5;
    localparam int CFG_W   = 32;
    localparam int PADDR_W = 3;

    // widest addresses over the supported residue counts (up to 64)
    localparam int ADDR_MAX_W  = 6;
    localparam int MADDR_MAX_W = 12;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
    localparam logic [VAL_W-1:0]   WEIGHT_RESET = 16'd256;

    localparam logic [ACT_W-1:0] ACT_LOAD_COUNT = 3'd0;
    localparam logic [ACT_W-1:0] ACT_LOAD_PROB  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_LOAD_BG    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_LOAD_MAT   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_PSEUDO     = 3'd4;
    localparam logic [ACT_W-1:0] ACT_SUBST      = 3'd5;
    localparam logic [ACT_W-1:0] ACT_READ       = 3'd6;

    localparam logic [ST_W-1:0] ST_OK         = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_SAMPLES = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD_INDEX  = 2'd2;

    // profile write source select
    localparam logic [1:0] WS_VALUE = 2'd0;
    localparam logic [1:0] WS_MIX   = 2'd1;
    localparam logic [1:0] WS_QUOT  = 2'd2;
    localparam logic [1:0] WS_ACC   = 2'd3;

    typedef logic [ADDR_MAX_W-1:0]  addr_t;
    typedef logic [MADDR_MAX_W-1:0] maddr_t;

    typedef struct packed {
        logic       prof_clr;
        logic       prof_we;
        logic [1:0] prof_wsel;
        addr_t      prof_addr;
        logic       bg_we;
        logic       mat_we;
        maddr_t     mat_raddr;
        logic       sum_clr;
        logic       sum_add;
        logic       tot_set;
        logic       mix_mul;
        logic       div_load;
        logic       div_step;
        logic       sub_pj;
        logic       sub_mul;
        logic       sub_acc;
        logic       sub_end;
        addr_t      sub_row;
    } cmd_t;

    typedef struct packed {
        logic             sum_zero;
        logic [VAL_W-1:0] rd_value;
    } stat_t;

endpackage

`default_nettype wire

// ===== design/ppsub_if.sv =====
//------------------------------------------------------------------------------
// ppsub_if
// Valid/ready channels for input items and result items.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ppsub_item_if;
    logic                          valid;
    logic                          ready;
    logic [ppsub_pkg::ACT_W-1:0]   action;
    logic [ppsub_pkg::IDX_W-1:0]   index;
    logic [ppsub_pkg::IDX_W-1:0]   column;
    logic [ppsub_pkg::VAL_W-1:0]   value;
    logic                          last;

    modport source (output valid, action, index, column, value, last, input ready);
    modport sink   (input valid, action, index, column, value, last, output ready);
endinterface

interface ppsub_result_if;
    logic                          valid;
    logic                          ready;
    logic [ppsub_pkg::VAL_W-1:0]   read_value;
    logic [ppsub_pkg::ST_W-1:0]    status;

    modport source (output valid, read_value, status, input ready);
    modport sink   (input valid, read_value, status, output ready);
endinterface

`default_nettype wire

// ===== design/ppsub_datapath.sv =====
//------------------------------------------------------------------------------
// ppsub_datapath
// Profile, background and matrix storage with the sum, mix, multiply-
// accumulate and restoring divider units.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppsub_datapath #(
    parameter int NUM_RESIDUES = ppsub_pkg::NUM_RESIDUES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire ppsub_pkg::cmd_t               cmd,
    input  wire logic [ppsub_pkg::IDX_W-1:0]   item_index,
    input  wire logic [ppsub_pkg::IDX_W-1:0]   item_column,
    input  wire logic [ppsub_pkg::VAL_W-1:0]   item_value,
    input  wire logic [ppsub_pkg::VAL_W-1:0]   pseudo_weight,
    output ppsub_pkg::stat_t                   stat
);

    localparam int AW     = $clog2(NUM_RESIDUES);
    localparam int MDEPTH = NUM_RESIDUES * NUM_RESIDUES;
    localparam int MAW    = $clog2(MDEPTH);
    localparam int PW     = ppsub_pkg::PROF_W;
    localparam int SUMW   = PW + $clog2(NUM_RESIDUES);
    localparam int RW     = SUMW + 1;
    localparam int QW     = ppsub_pkg::QUO_W;
    localparam int TW     = ppsub_pkg::TOTAL_W;
    localparam int VW     = ppsub_pkg::VAL_W;
    localparam int PAW    = QW + TW;
    localparam int PBW    = 2 * VW;
    localparam int SPW    = QW + VW;

    logic [PW-1:0]           prof_arr [NUM_RESIDUES];
    logic [NUM_RESIDUES-1:0] prof_vld_reg;
    logic [NUM_RESIDUES-1:0] prof_vld_next;
    logic [VW-1:0]           bg_arr [NUM_RESIDUES];
    logic [PW-1:0]           acc_arr [NUM_RESIDUES];
    logic [VW-1:0]           mat_mem [MDEPTH];
    logic [VW-1:0]           mdata_reg;

    logic [SUMW-1:0] sum_reg;
    logic [TW-1:0]   total_reg;
    logic [RW-1:0]   r_reg;
    logic [QW-1:0]   q_reg;
    logic [PAW-1:0]  prod_a_reg;
    logic [PBW-1:0]  prod_b_reg;
    logic [QW-1:0]   pj_reg;
    logic [SPW-1:0]  sprod_reg;
    logic [PW-1:0]   acc_reg;

    logic [AW-1:0]   addr;
    logic [MAW-1:0]  mat_waddr;
    logic [PW-1:0]   prof_rd;
    logic [PW-1:0]   mix_sum;
    logic [PW-1:0]   wdata;
    logic            ge;
    logic [RW-1:0]   rem;
    logic [PW-1:0]   acc_sum;

    assign addr      = cmd.prof_addr[AW-1:0];
    assign mat_waddr = MAW'(32'(item_index) * 32'(NUM_RESIDUES) + 32'(item_column));
    assign prof_rd   = prof_vld_reg[addr] ? prof_arr[addr] : '0;
    assign mix_sum   = PW'(prod_a_reg) + PW'(prod_b_reg[PBW-1:8]);
    assign ge        = r_reg >= {1'b0, sum_reg};
    assign rem       = ge ? (r_reg - {1'b0, sum_reg}) : r_reg;
    assign acc_sum   = acc_reg + PW'(sprod_reg);

    assign stat.sum_zero = (sum_reg == '0);
    assign stat.rd_value = (prof_rd > PW'({VW{1'b1}})) ? {VW{1'b1}} : prof_rd[VW-1:0];

    always_comb
    begin
        case (cmd.prof_wsel)
            ppsub_pkg::WS_VALUE: wdata = PW'(item_value);
            ppsub_pkg::WS_MIX:   wdata = mix_sum;
            ppsub_pkg::WS_QUOT:  wdata = PW'(q_reg);
            default:             wdata = acc_arr[addr];
        endcase
    end

    // valid bits: a cleared entry reads as zero
    always_comb
    begin
        prof_vld_next = cmd.prof_clr ? '0 : prof_vld_reg;
        if (cmd.prof_we)
            prof_vld_next[addr] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prof_vld_reg <= '0;
        end
        else
        begin
            prof_vld_reg <= prof_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prof_we)
            prof_arr[addr] <= wdata;
        if (cmd.bg_we)
            bg_arr[addr] <= item_value;
        if (cmd.sub_end)
            acc_arr[cmd.sub_row[AW-1:0]] <= acc_sum;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mat_we)
            mat_mem[mat_waddr] <= item_value;
        mdata_reg <= mat_mem[cmd.mat_raddr[MAW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            total_reg <= '0;
        end
        else
        begin
            if (cmd.sum_clr)
                sum_reg <= '0;
            else if (cmd.sum_add)
                sum_reg <= sum_reg + SUMW'(prof_rd);
            if (cmd.tot_set)
                total_reg <= (sum_reg > SUMW'(ppsub_pkg::TOTAL_MAX)) ?
                             ppsub_pkg::TOTAL_MAX : sum_reg[TW-1:0];
        end
    end

    // one quotient bit per step, remainder kept below twice the divisor
    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            r_reg <= RW'(prof_rd);
            q_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            r_reg <= {rem[RW-2:0], 1'b0};
            q_reg <= {q_reg[QW-2:0], ge};
        end
    end

    // entries at rest never exceed 1.0, so the low QW bits carry them
    always_ff @(posedge clk)
    begin
        if (cmd.mix_mul)
        begin
            prod_a_reg <= prof_rd[QW-1:0] * total_reg;
            prod_b_reg <= bg_arr[addr] * pseudo_weight;
        end
        if (cmd.sub_pj)
            pj_reg <= prof_rd[QW-1:0];
        if (cmd.sub_mul)
            sprod_reg <= pj_reg * mdata_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (cmd.sub_acc)
        begin
            acc_reg <= cmd.sub_end ? '0 : acc_sum;
        end
    end

endmodule

`default_nettype wire

// ===== design/ppsub_ctrl.sv =====
//------------------------------------------------------------------------------
// ppsub_ctrl
// Sequencer: accepts items, steps the datapath through load, sum, divide,
// mix and substitution passes, and holds the result register.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppsub_ctrl #(
    parameter int NUM_RESIDUES = ppsub_pkg::NUM_RESIDUES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    output logic                               item_ready,
    input  wire logic [ppsub_pkg::ACT_W-1:0]   item_action,
    input  wire logic [ppsub_pkg::IDX_W-1:0]   item_index,
    input  wire logic [ppsub_pkg::IDX_W-1:0]   item_column,
    input  wire logic                          item_last,
    output logic                               result_valid,
    input  wire logic                          result_ready,
    output logic [ppsub_pkg::VAL_W-1:0]        result_value,
    output logic [ppsub_pkg::ST_W-1:0]         result_status,
    output ppsub_pkg::cmd_t                    cmd,
    input  wire ppsub_pkg::stat_t              stat
);

    localparam int AW  = $clog2(NUM_RESIDUES);
    localparam int MAW = $clog2(NUM_RESIDUES * NUM_RESIDUES);
    localparam int SW  = ppsub_pkg::STEP_W;
    localparam int VW  = ppsub_pkg::VAL_W;
    localparam int TW  = ppsub_pkg::ST_W;
    localparam logic [AW-1:0] LAST_IDX  = AW'(NUM_RESIDUES - 1);
    localparam logic [SW-1:0] LAST_STEP = SW'(ppsub_pkg::QUO_W - 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DONE   = 4'd1;
    localparam logic [3:0] S_SUM    = 4'd2;
    localparam logic [3:0] S_CHK    = 4'd3;
    localparam logic [3:0] S_DIVLD  = 4'd4;
    localparam logic [3:0] S_DIV    = 4'd5;
    localparam logic [3:0] S_DIVWR  = 4'd6;
    localparam logic [3:0] S_MIXMUL = 4'd7;
    localparam logic [3:0] S_MIXWR  = 4'd8;
    localparam logic [3:0] S_SUB    = 4'd9;
    localparam logic [3:0] S_SUBFL  = 4'd10;
    localparam logic [3:0] S_COPY   = 4'd11;

    logic [3:0]    state_reg, state_next;
    logic [AW-1:0] i_reg, i_next;
    logic [AW-1:0] col_reg, col_next;
    logic [AW-1:0] row_reg, row_next;
    logic [MAW-1:0] maddr_reg, maddr_next;
    logic [SW-1:0] step_reg, step_next;
    logic          known_reg, known_next;
    logic          open_reg, open_next;
    logic          cnt_reg, cnt_next;
    logic [TW-1:0] st_pend_reg, st_pend_next;
    logic [VW-1:0] rd_pend_reg, rd_pend_next;
    logic          s1_v_reg, s1_v_next;
    logic          s1_end_reg, s1_end_next;
    logic [AW-1:0] s1_row_reg, s1_row_next;
    logic          s2_v_reg;
    logic          s2_end_reg;
    logic [AW-1:0] s2_row_reg;
    logic          out_v_reg, out_v_next;
    logic [VW-1:0] out_val_reg, out_val_next;
    logic [TW-1:0] out_st_reg, out_st_next;

    logic accept;
    logic bad_idx;
    logic bad_col;

    assign item_ready    = (state_reg == S_IDLE);
    assign accept        = item_valid && item_ready;
    assign bad_idx       = 32'(item_index) >= 32'(NUM_RESIDUES);
    assign bad_col       = 32'(item_column) >= 32'(NUM_RESIDUES);
    assign result_valid  = out_v_reg;
    assign result_value  = out_val_reg;
    assign result_status = out_st_reg;

    always_comb
    begin
        state_next   = state_reg;
        i_next       = i_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        maddr_next   = maddr_reg;
        step_next    = step_reg;
        known_next   = known_reg;
        open_next    = open_reg;
        cnt_next     = cnt_reg;
        st_pend_next = st_pend_reg;
        rd_pend_next = rd_pend_reg;
        s1_v_next    = 1'b0;
        s1_end_next  = 1'b0;
        s1_row_next  = row_reg;
        out_v_next   = out_v_reg && !result_ready;
        out_val_next = out_val_reg;
        out_st_next  = out_st_reg;

        cmd           = '0;
        cmd.prof_addr = ppsub_pkg::addr_t'(i_reg);
        cmd.mat_raddr = ppsub_pkg::maddr_t'(maddr_reg);
        cmd.sub_mul   = s1_v_reg;
        cmd.sub_acc   = s2_v_reg;
        cmd.sub_end   = s2_v_reg && s2_end_reg;
        cmd.sub_row   = ppsub_pkg::addr_t'(s2_row_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.prof_addr = ppsub_pkg::addr_t'(item_index);
                    st_pend_next  = ppsub_pkg::ST_OK;
                    rd_pend_next  = '0;
                    state_next    = S_DONE;
                    i_next        = '0;
                    case (item_action)
                        ppsub_pkg::ACT_LOAD_COUNT, ppsub_pkg::ACT_LOAD_PROB:
                        begin
                            if (bad_idx)
                            begin
                                st_pend_next = ppsub_pkg::ST_BAD_INDEX;
                            end
                            else
                            begin
                                cmd.prof_clr  = !open_reg;
                                cmd.prof_we   = 1'b1;
                                cmd.prof_wsel = ppsub_pkg::WS_VALUE;
                                open_next     = 1'b1;
                                if (item_last)
                                begin
                                    open_next   = 1'b0;
                                    cnt_next    = (item_action == ppsub_pkg::ACT_LOAD_COUNT);
                                    known_next  = (item_action == ppsub_pkg::ACT_LOAD_COUNT);
                                    cmd.sum_clr = 1'b1;
                                    state_next  = S_SUM;
                                end
                            end
                        end
                        ppsub_pkg::ACT_LOAD_BG:
                        begin
                            if (bad_idx)
                                st_pend_next = ppsub_pkg::ST_BAD_INDEX;
                            else
                                cmd.bg_we = 1'b1;
                        end
                        ppsub_pkg::ACT_LOAD_MAT:
                        begin
                            if (bad_idx || bad_col)
                                st_pend_next = ppsub_pkg::ST_BAD_INDEX;
                            else
                                cmd.mat_we = 1'b1;
                        end
                        ppsub_pkg::ACT_PSEUDO:
                        begin
                            if (!known_reg)
                            begin
                                st_pend_next = ppsub_pkg::ST_NO_SAMPLES;
                            end
                            else
                            begin
                                known_next = 1'b0;
                                state_next = S_MIXMUL;
                            end
                        end
                        ppsub_pkg::ACT_SUBST:
                        begin
                            known_next = 1'b0;
                            col_next   = '0;
                            row_next   = '0;
                            maddr_next = '0;
                            state_next = S_SUB;
                        end
                        ppsub_pkg::ACT_READ:
                        begin
                            if (bad_idx)
                                st_pend_next = ppsub_pkg::ST_BAD_INDEX;
                            else
                                rd_pend_next = stat.rd_value;
                        end
                        default:
                        begin
                            st_pend_next = ppsub_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_DONE:
            begin
                if (!out_v_reg || result_ready)
                begin
                    out_v_next   = 1'b1;
                    out_val_next = rd_pend_reg;
                    out_st_next  = st_pend_reg;
                    state_next   = S_IDLE;
                end
            end
            S_SUM:
            begin
                cmd.sum_add = 1'b1;
                if (i_reg == LAST_IDX)
                begin
                    state_next = S_CHK;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            S_CHK:
            begin
                cmd.tot_set = cnt_reg;
                i_next      = '0;
                state_next  = stat.sum_zero ? S_DONE : S_DIVLD;
            end
            S_DIVLD:
            begin
                cmd.div_load = 1'b1;
                step_next    = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                    state_next = S_DIVWR;
            end
            S_DIVWR:
            begin
                cmd.prof_we   = 1'b1;
                cmd.prof_wsel = ppsub_pkg::WS_QUOT;
                if (i_reg == LAST_IDX)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_DIVLD;
                end
            end
            S_MIXMUL:
            begin
                cmd.mix_mul = 1'b1;
                state_next  = S_MIXWR;
            end
            S_MIXWR:
            begin
                cmd.prof_we   = 1'b1;
                cmd.prof_wsel = ppsub_pkg::WS_MIX;
                if (i_reg == LAST_IDX)
                begin
                    i_next      = '0;
                    cnt_next    = 1'b0;
                    cmd.sum_clr = 1'b1;
                    state_next  = S_SUM;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_MIXMUL;
                end
            end
            S_SUB:
            begin
                // issue one matrix element per cycle; pj_reg/mdata_reg feed the sprod_reg product
                cmd.prof_addr = ppsub_pkg::addr_t'(col_reg);
                cmd.sub_pj    = 1'b1;
                s1_v_next     = 1'b1;
                s1_end_next   = (col_reg == LAST_IDX);
                s1_row_next   = row_reg;
                maddr_next    = maddr_reg + 1'b1;
                if (col_reg == LAST_IDX)
                begin
                    col_next = '0;
                    row_next = row_reg + 1'b1;
                    if (row_reg == LAST_IDX)
                        state_next = S_SUBFL;
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            S_SUBFL:
            begin
                if (!s1_v_reg && !s2_v_reg)
                begin
                    i_next     = '0;
                    state_next = S_COPY;
                end
            end
            S_COPY:
            begin
                cmd.prof_we   = 1'b1;
                cmd.prof_wsel = ppsub_pkg::WS_ACC;
                if (i_reg == LAST_IDX)
                begin
                    i_next      = '0;
                    cnt_next    = 1'b0;
                    cmd.sum_clr = 1'b1;
                    state_next  = S_SUM;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            i_reg      <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            maddr_reg  <= '0;
            step_reg   <= '0;
            known_reg  <= 1'b0;
            open_reg   <= 1'b0;
            cnt_reg    <= 1'b0;
            s1_v_reg   <= 1'b0;
            s1_end_reg <= 1'b0;
            s2_v_reg   <= 1'b0;
            s2_end_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            i_reg      <= i_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            maddr_reg  <= maddr_next;
            step_reg   <= step_next;
            known_reg  <= known_next;
            open_reg   <= open_next;
            cnt_reg    <= cnt_next;
            s1_v_reg   <= s1_v_next;
            s1_end_reg <= s1_end_next;
            s2_v_reg   <= s1_v_reg;
            s2_end_reg <= s1_end_reg;
            out_v_reg  <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_pend_reg <= st_pend_next;
        rd_pend_reg <= rd_pend_next;
        s1_row_reg  <= s1_row_next;
        s2_row_reg  <= s1_row_reg;
        out_val_reg <= out_val_next;
        out_st_reg  <= out_st_next;
    end

endmodule

`default_nettype wire

// ===== design/profile_pseudocount_substitution.sv =====
//------------------------------------------------------------------------------
// profile_pseudocount_substitution
// Residue profile with count/probability loads, pseudocount mixing,
// substitution-matrix transform and in-place renormalization.
//------------------------------------------------------------------------------
//  Channel  Dir  Handshake            Payload
//  item     in   valid/ready          action, index, column, value, last
//  result   out  valid/ready          read_value, status
//  cfg      in   APB write/read       pseudo_weight at byte address 0
//
//  A closing load runs a sum pass and a divide per entry; pseudocount adds a
//  mix pass and substitution a matrix pass, each followed by renormalization.
//  The divider yields one quotient bit per cycle and the matrix memory has a
//  single read port.
//  Reset clears control state and the profile valid bits; no clearing pass.
//  A new item is taken while the previous result still waits on result.ready.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module profile_pseudocount_substitution #(
    parameter int NUM_RESIDUES = ppsub_pkg::NUM_RESIDUES_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    ppsub_item_if.sink                            item,
    ppsub_result_if.source                        result,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [ppsub_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [ppsub_pkg::CFG_W-1:0]      pwdata,
    output logic [ppsub_pkg::CFG_W-1:0]           prdata,
    output logic                                  pready
);

    localparam int VW = ppsub_pkg::VAL_W;

    logic [VW-1:0]    weight_reg;
    ppsub_pkg::cmd_t  cmd;
    ppsub_pkg::stat_t stat;
    logic             wsel;

    // register index sits above the byte offset
    assign wsel   = (paddr[ppsub_pkg::PADDR_W-1] == 1'b0);
    assign pready = 1'b1;
    assign prdata = wsel ? ppsub_pkg::CFG_W'(weight_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            weight_reg <= ppsub_pkg::WEIGHT_RESET;
        else if (psel && penable && pwrite && wsel)
            weight_reg <= pwdata[VW-1:0];
    end

    ppsub_ctrl #(
        .NUM_RESIDUES (NUM_RESIDUES)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item.valid),
        .item_ready    (item.ready),
        .item_action   (item.action),
        .item_index    (item.index),
        .item_column   (item.column),
        .item_last     (item.last),
        .result_valid  (result.valid),
        .result_ready  (result.ready),
        .result_value  (result.read_value),
        .result_status (result.status),
        .cmd           (cmd),
        .stat          (stat)
    );

    ppsub_datapath #(
        .NUM_RESIDUES (NUM_RESIDUES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .item_index    (item.index),
        .item_column   (item.column),
        .item_value    (item.value),
        .pseudo_weight (weight_reg),
        .stat          (stat)
    );

endmodule

`default_nettype wire
